FILE: design/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by lkvc_lookup and lru_key_value_cache_core.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [CFG_W-1:0]  CAPACITY_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE     = {DATA_W{1'b1}};

    typedef struct packed {
        logic hit;
        logic update;
        logic insert;
    } lkvc_status_t;

endpackage

`default_nettype wire

FILE: design/lkvc_lookup.sv
// Parallel key compare, slot selection and recency update for one request.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_lookup #(
    parameter int ENTRIES = 16,
    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int OCC_W = $clog2(ENTRIES + 1)
) (
    input  wire logic                        op,
    input  wire logic [lkvc_pkg::KEY_W-1:0]  key,
    input  wire logic [lkvc_pkg::CFG_W-1:0]  capacity,
    input  wire logic [ENTRIES-1:0]          valid,
    input  wire logic [lkvc_pkg::KEY_W-1:0]  entry_key [ENTRIES],
    input  wire logic [lkvc_pkg::DATA_W-1:0] entry_data [ENTRIES],
    input  wire logic [AGE_W-1:0]            age [ENTRIES],
    input  wire logic [OCC_W-1:0]            occupancy,
    output lkvc_pkg::lkvc_status_t           status,
    output logic [ENTRIES-1:0]               target,
    output logic [AGE_W-1:0]                 age_next [ENTRIES],
    output logic [lkvc_pkg::DATA_W-1:0]      read_value
);

    logic [ENTRIES-1:0]          match;
    logic [ENTRIES-1:0]          free_oh;
    logic [ENTRIES-1:0]          oldest_oh;
    logic [AGE_W-1:0]            hit_age;
    logic [lkvc_pkg::DATA_W-1:0] hit_data;
    logic [OCC_W-1:0]            eff_cap;
    logic [OCC_W-1:0]            occ_m1;
    logic                        hit;
    logic                        room;
    logic                        age_all;
    logic                        promote;

    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = OCC_W'(1);
        end
        else if (32'(capacity) > 32'(ENTRIES))
        begin
            eff_cap = OCC_W'(ENTRIES);
        end
        else
        begin
            eff_cap = OCC_W'(capacity);
        end
    end

    assign room   = occupancy < eff_cap;
    assign occ_m1 = occupancy - OCC_W'(1);

    always_comb
    begin
        hit_age  = '0;
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]     = valid[i] && (entry_key[i] == key);
            free_oh[i]   = occupancy == OCC_W'(i);
            oldest_oh[i] = valid[i] && (OCC_W'(age[i]) == occ_m1);
            if (match[i])
            begin
                hit_age  = hit_age | age[i];
                hit_data = hit_data | entry_data[i];
            end
        end
    end

    assign hit        = |match;
    assign read_value = hit ? hit_data : lkvc_pkg::MISS_VALUE;

    assign age_all = !hit;
    assign promote = hit || (op == lkvc_pkg::OP_PUT);

    always_comb
    begin
        if (hit)
        begin
            target = match;
        end
        else if (room)
        begin
            target = free_oh;
        end
        else
        begin
            target = oldest_oh;
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age[i];
            if (promote)
            begin
                if (target[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid[i] && (age_all || (age[i] < hit_age)))
                begin
                    age_next[i] = AGE_W'(age[i] + 1'b1);
                end
            end
        end
    end

    assign status.hit    = hit;
    assign status.update = promote;
    assign status.insert = (op == lkvc_pkg::OP_PUT) && !hit && room;

endmodule

`default_nettype wire

FILE: design/lru_key_value_cache_core.sv
// Requests pass the request register; a GET's result then lands in the output register.
// Throughput: one request per cycle while no GET waits on a full, unready output;
// the compare over all entries and the age update sit between request and result registers.
// Reset: valid marks, ages and occupancy cleared, capacity set to 16; no clearing pass.
// Top level of the LRU key-value cache; depends on lkvc_pkg and lkvc_lookup.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lkvc_pkg::CFG_W-1:0]    cfg_wr_data,  // capacity
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,      // [31:0] key, [63:32] value
    input  wire logic [0:0]                    s_tuser,      // [0] operation
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,      // [31:0] read_value
    output logic [0:0]                         m_tuser       // [0] hit
);

    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    logic                          req_valid_reg;
    logic                          req_op_reg;
    logic [lkvc_pkg::KEY_W-1:0]    req_key_reg;
    logic [lkvc_pkg::DATA_W-1:0]   req_value_reg;
    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [lkvc_pkg::DATA_W-1:0]   out_data_reg;
    logic [lkvc_pkg::CFG_W-1:0]    capacity_reg;
    logic [ENTRIES-1:0]            valid_reg;
    logic [AGE_W-1:0]              age_reg [ENTRIES];
    logic [OCC_W-1:0]              occupancy_reg;
    logic [lkvc_pkg::KEY_W-1:0]    key_reg [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0]   data_reg [ENTRIES];

    lkvc_pkg::lkvc_status_t        status;
    logic [ENTRIES-1:0]            target;
    logic [AGE_W-1:0]              age_next [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0]   read_value;
    logic                          advance;

    lkvc_lookup #(
        .ENTRIES (ENTRIES)
    ) u_lookup (
        .op         (req_op_reg),
        .key        (req_key_reg),
        .capacity   (capacity_reg),
        .valid      (valid_reg),
        .entry_key  (key_reg),
        .entry_data (data_reg),
        .age        (age_reg),
        .occupancy  (occupancy_reg),
        .status     (status),
        .target     (target),
        .age_next   (age_next),
        .read_value (read_value)
    );

    assign advance  = req_valid_reg
                   && ((req_op_reg == lkvc_pkg::OP_PUT) || !out_valid_reg || m_tready);
    assign s_tready = !req_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= lkvc_pkg::CAPACITY_RESET;
            valid_reg     <= '0;
            occupancy_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                req_valid_reg <= s_tvalid;
            end
            if (advance && (req_op_reg == lkvc_pkg::OP_GET))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                age_reg <= age_next;
                if (status.insert)
                begin
                    valid_reg     <= valid_reg | target;
                    occupancy_reg <= OCC_W'(occupancy_reg + 1'b1);
                end
            end
        end
    end

    // payload: request, result and entry store hold without reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_op_reg    <= s_tuser[0];
            req_key_reg   <= s_tdata[31:0];
            req_value_reg <= s_tdata[63:32];
        end
        if (advance && (req_op_reg == lkvc_pkg::OP_GET))
        begin
            out_hit_reg  <= status.hit;
            out_data_reg <= read_value;
        end
        if (advance && (req_op_reg == lkvc_pkg::OP_PUT))
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (target[i])
                begin
                    key_reg[i]  <= req_key_reg;
                    data_reg[i] <= req_value_reg;
                end
            end
        end
    end

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(occupancy_reg))
        else $error("occupancy out of step with valid marks");

    a_target_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        advance && status.update |-> $onehot(target))
        else $error("update target not one-hot");

    a_put_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (req_op_reg == lkvc_pkg::OP_PUT) && !out_valid_reg |=> !m_tvalid)
        else $error("put request raised a result");

endmodule

`default_nettype wire
